// ===== sv/sorm_pkg.sv =====
package sorm_pkg;

    localparam int DEF_MAX_STEPS = 32;
    localparam int DEF_MAX_RINGS = 256;

    localparam int ANG_W = 18;
    localparam int STEP_W = 6;
    localparam int DATA_W = 32;
    localparam int IDX_W = 14;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W = 20;
    localparam int DIV_CNT_W = 5;
    localparam int TRIG_W = 31;
    localparam int K_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd2;

    localparam logic [ANG_W-1:0]  START_RST = 18'd0;
    localparam logic [ANG_W-1:0]  STOP_RST  = 18'd65536;
    localparam logic [STEP_W-1:0] STEPS_RST = 6'd32;
    localparam logic [ANG_W-1:0]  ONE_TURN  = 18'd65536;

    localparam logic [32:0] RAD_K = 33'd6746518852;
    localparam logic [TRIG_W-1:0] Q30_ONE = 31'd1073741824;

    // first and last Horner step of each series
    localparam logic [K_W-1:0] K_SIN_FIRST = 4'd0;
    localparam logic [K_W-1:0] K_SIN_LAST  = 4'd4;
    localparam logic [K_W-1:0] K_COS_FIRST = 4'd5;
    localparam logic [K_W-1:0] K_COS_LAST  = 4'd10;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_DIV_STEP, OP_DIV_END, OP_ANG_MUL, OP_X, OP_X_SQ,
        OP_X2, OP_HMUL, OP_RECIP, OP_CORR, OP_SMUL, OP_SIN, OP_UNFOLD,
        OP_RMUL_X, OP_SCALE_X, OP_RMUL_Y, OP_SCALE_Y, OP_LOAD
    } op_t;

    typedef struct packed {
        op_t            op;
        logic [K_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic produce;
        logic ring_zero;
        logic last_col;
        logic out_free;
    } dp_status_t;

    // Horner divisors: sin 110,72,42,20,6 then cos 132,90,56,30,12,2
    function automatic logic [7:0] horner_div(input logic [K_W-1:0] k);
        logic [7:0] d;
        case (k)
            4'd0:    d = 8'd110;
            4'd1:    d = 8'd72;
            4'd2:    d = 8'd42;
            4'd3:    d = 8'd20;
            4'd4:    d = 8'd6;
            4'd5:    d = 8'd132;
            4'd6:    d = 8'd90;
            4'd7:    d = 8'd56;
            4'd8:    d = 8'd30;
            4'd9:    d = 8'd12;
            4'd10:   d = 8'd2;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // floor(2^31 / d) for the divisors above
    function automatic logic [TRIG_W-1:0] horner_recip(input logic [K_W-1:0] k);
        logic [TRIG_W-1:0] m;
        case (k)
            4'd0:    m = 31'(64'd2147483648 / 64'd110);
            4'd1:    m = 31'(64'd2147483648 / 64'd72);
            4'd2:    m = 31'(64'd2147483648 / 64'd42);
            4'd3:    m = 31'(64'd2147483648 / 64'd20);
            4'd4:    m = 31'(64'd2147483648 / 64'd6);
            4'd5:    m = 31'(64'd2147483648 / 64'd132);
            4'd6:    m = 31'(64'd2147483648 / 64'd90);
            4'd7:    m = 31'(64'd2147483648 / 64'd56);
            4'd8:    m = 31'(64'd2147483648 / 64'd30);
            4'd9:    m = 31'(64'd2147483648 / 64'd12);
            4'd10:   m = 31'(64'd2147483648 / 64'd2);
            default: m = 31'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/sorm_ctrl.sv =====
module sorm_ctrl import sorm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [17:0] {
        ST_IDLE   = 18'h00001,
        ST_DIV    = 18'h00002,
        ST_DIVEND = 18'h00004,
        ST_ANGMUL = 18'h00008,
        ST_X      = 18'h00010,
        ST_XSQ    = 18'h00020,
        ST_X2     = 18'h00040,
        ST_HMUL   = 18'h00080,
        ST_RECIP  = 18'h00100,
        ST_CORR   = 18'h00200,
        ST_SMUL   = 18'h00400,
        ST_SIN    = 18'h00800,
        ST_UNFOLD = 18'h01000,
        ST_RMX    = 18'h02000,
        ST_SCX    = 18'h04000,
        ST_RMY    = 18'h08000,
        ST_SCY    = 18'h10000,
        ST_LOAD   = 18'h20000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [K_W-1:0]       k_reg, k_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        cmd.op     = OP_NONE;
        cmd.k      = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op   = OP_ACCEPT;
                    cnt_next = '0;
                    if (!status.produce) state_next = ST_IDLE;
                    else if (status.ring_zero) state_next = ST_DIV;
                    else state_next = ST_ANGMUL;
                end
            end
            ST_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) state_next = ST_DIVEND;
            end
            ST_DIVEND: begin
                cmd.op     = OP_DIV_END;
                state_next = ST_ANGMUL;
            end
            ST_ANGMUL: begin
                cmd.op     = OP_ANG_MUL;
                state_next = ST_X;
            end
            ST_X: begin
                cmd.op     = OP_X;
                state_next = ST_XSQ;
            end
            ST_XSQ: begin
                cmd.op     = OP_X_SQ;
                state_next = ST_X2;
            end
            ST_X2: begin
                cmd.op     = OP_X2;
                k_next     = K_SIN_FIRST;
                state_next = ST_RECIP;
            end
            ST_HMUL: begin
                cmd.op     = OP_HMUL;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.op     = OP_RECIP;
                state_next = ST_CORR;
            end
            ST_CORR: begin
                cmd.op = OP_CORR;
                k_next = k_reg + 1'b1;
                if (k_reg == K_SIN_LAST) state_next = ST_SMUL;
                else if (k_reg == K_COS_LAST) state_next = ST_UNFOLD;
                else state_next = ST_HMUL;
            end
            ST_SMUL: begin
                cmd.op     = OP_SMUL;
                state_next = ST_SIN;
            end
            ST_SIN: begin
                cmd.op     = OP_SIN;
                state_next = ST_RECIP;  // first cosine step
            end
            ST_UNFOLD: begin
                cmd.op     = OP_UNFOLD;
                state_next = ST_RMX;
            end
            ST_RMX: begin
                cmd.op     = OP_RMUL_X;
                state_next = ST_SCX;
            end
            ST_SCX: begin
                cmd.op     = OP_SCALE_X;
                state_next = ST_RMY;
            end
            ST_RMY: begin
                cmd.op     = OP_RMUL_Y;
                state_next = ST_SCY;
            end
            ST_SCY: begin
                cmd.op     = OP_SCALE_Y;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.op     = OP_LOAD;
                    state_next = status.last_col ? ST_IDLE : ST_ANGMUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/sorm_datapath.sv =====
module sorm_datapath import sorm_pkg::*; #(
    parameter int MAX_STEPS = DEF_MAX_STEPS,
    parameter int MAX_RINGS = DEF_MAX_RINGS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [ANG_W-1:0]         cfg_data,
    input  logic signed [DATA_W-1:0] s_radius,
    input  logic signed [DATA_W-1:0] s_height,
    input  logic                     s_last_point,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_pos_x,
    output logic signed [DATA_W-1:0] m_pos_y,
    output logic signed [DATA_W-1:0] m_pos_z,
    output logic [IDX_W-1:0]         m_vertex_index,
    output logic                     m_faces_valid,
    output logic [IDX_W-1:0]         m_face_a_first,
    output logic [IDX_W-1:0]         m_face_a_second,
    output logic [IDX_W-1:0]         m_face_a_third,
    output logic [IDX_W-1:0]         m_face_b_first,
    output logic [IDX_W-1:0]         m_face_b_second,
    output logic [IDX_W-1:0]         m_face_b_third,
    output logic                     m_run_end,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status
);

    localparam int CW  = $clog2(MAX_STEPS + 2);
    localparam int RGW = $clog2(MAX_RINGS + 1);
    localparam int BW  = IDX_W + RGW + CW;

    // configuration
    logic [ANG_W-1:0]  start_reg, stop_reg;
    logic [STEP_W-1:0] steps_reg;

    // per-word state
    logic [RGW-1:0]           ring_reg;
    logic signed [DATA_W-1:0] r_reg;
    logic [DATA_W-1:0]        z_reg;
    logic [CW-1:0]            n_reg, np_reg, col_reg;
    logic                     full_reg, faces_reg;
    logic [IDX_W-1:0]         base_reg, prev_reg;
    logic [15:0]              ang_reg;
    logic [ANG_W-1:0]         inc_reg;
    logic [DIV_W-1:0]         num_reg;
    logic [6:0]               rem_reg;
    logic                     neg_reg;

    // trig
    logic               swap_reg;
    logic [1:0]         quad_reg;
    logic [63:0]        prod_reg;
    logic [TRIG_W-1:0]  x_reg, x2_reg, t_reg, v_reg, s_reg;
    logic signed [DATA_W-1:0] cs_reg, sn_reg, px_reg, py_reg;

    logic out_valid_reg;

    // ---- accept-time values
    logic [CW-1:0]       n_clamp, np_calc;
    logic                full_calc;
    logic signed [ANG_W:0] diff;
    logic [ANG_W:0]      diff_mag;
    logic [BW-1:0]       base_full;
    logic [IDX_W-1:0]    base_calc;

    always_comb begin
        if (steps_reg == '0) n_clamp = CW'(1);
        else if (int'(steps_reg) > MAX_STEPS) n_clamp = CW'(MAX_STEPS);
        else n_clamp = CW'(steps_reg);
        full_calc = (start_reg == '0) && (stop_reg == ONE_TURN);
        np_calc   = full_calc ? n_clamp : n_clamp + 1'b1;
        diff      = $signed({stop_reg[ANG_W-1], stop_reg})
                  - $signed({start_reg[ANG_W-1], start_reg});
        diff_mag  = diff[ANG_W] ? (ANG_W+1)'(-diff) : (ANG_W+1)'(diff);
        base_full = BW'(ring_reg) * BW'(np_calc);
        base_calc = base_full[IDX_W-1:0];
    end

    // ---- divider step
    logic [6:0] rem_sh;
    logic       rem_ge;
    assign rem_sh = {rem_reg[5:0], num_reg[DIV_W-1]};
    assign rem_ge = (rem_sh >= 7'(n_reg));

    // ---- increment saturation
    logic [ANG_W-1:0] inc_sat;
    always_comb begin
        if (neg_reg) begin
            if (num_reg > DIV_W'(131072)) inc_sat = 18'h20000;
            else inc_sat = ANG_W'(-num_reg);
        end else begin
            if (num_reg > DIV_W'(131071)) inc_sat = 18'h1FFFF;
            else inc_sat = num_reg[ANG_W-1:0];
        end
    end

    // ---- octant fold
    logic [13:0] rem_ang, fold_calc;
    logic        swap_calc;
    always_comb begin
        rem_ang   = ang_reg[13:0];
        swap_calc = (rem_ang > 14'd8192);
        fold_calc = swap_calc ? 14'(15'd16384 - 15'(rem_ang)) : rem_ang;
    end

    // ---- Horner step
    logic [TRIG_W-1:0] v_sel;
    logic [TRIG_W-1:0] q0, q_fix;
    logic [TRIG_W+8:0] qd;
    logic [TRIG_W+8:0] r_left;
    logic [7:0]        dk;
    always_comb begin
        dk     = horner_div(cmd.k);
        v_sel  = (cmd.k == K_SIN_FIRST || cmd.k == K_COS_FIRST) ? x2_reg
                                                                 : prod_reg[60:30];
        q0     = prod_reg[61:31];
        qd     = (TRIG_W+9)'(q0) * (TRIG_W+9)'(dk);
        r_left = (TRIG_W+9)'(v_reg) - qd;
        q_fix  = (r_left >= (TRIG_W+9)'(dk)) ? q0 + 1'b1 : q0;
    end

    // ---- unfold
    logic signed [DATA_W-1:0] cb, sb, cs_calc, sn_calc;
    always_comb begin
        cb = swap_reg ? DATA_W'(s_reg) : DATA_W'(t_reg);
        sb = swap_reg ? DATA_W'(t_reg) : DATA_W'(s_reg);
        case (quad_reg)
            2'd0:    begin cs_calc = cb;  sn_calc = sb;  end
            2'd1:    begin cs_calc = -sb; sn_calc = cb;  end
            2'd2:    begin cs_calc = -cb; sn_calc = -sb; end
            default: begin cs_calc = sb;  sn_calc = -cb; end
        endcase
    end

    // ---- position scale: round half away from zero, saturate
    logic        p_neg;
    logic [63:0] p_mag, p_rnd;
    logic [33:0] p_q;
    logic signed [DATA_W-1:0] pos_calc;
    always_comb begin
        p_neg = prod_reg[63];
        p_mag = p_neg ? -prod_reg : prod_reg;
        p_rnd = p_mag + 64'h2000_0000;
        p_q   = p_rnd[63:30];
        if (p_neg) begin
            if (p_q > 34'h0_8000_0000) pos_calc = 32'sh8000_0000;
            else pos_calc = DATA_W'(-p_q);
        end else begin
            if (p_q > 34'h0_7FFF_FFFF) pos_calc = 32'sh7FFF_FFFF;
            else pos_calc = DATA_W'(p_q);
        end
    end

    // ---- face indices
    logic [IDX_W-1:0] vi, vi1, pj, pj1, ck, pk;
    logic [CW-1:0]    kcol;
    logic             last_col;
    always_comb begin
        last_col = (col_reg + 1'b1 == np_reg);
        kcol     = (col_reg + 1'b1 == n_reg) ? '0 : col_reg + 1'b1;
        vi  = base_reg + IDX_W'(col_reg);
        vi1 = vi + 1'b1;
        pj  = prev_reg + IDX_W'(col_reg);
        pj1 = pj + 1'b1;
        ck  = base_reg + IDX_W'(kcol);
        pk  = prev_reg + IDX_W'(kcol);
    end

    assign status.produce   = (int'(ring_reg) < MAX_RINGS);
    assign status.ring_zero = (ring_reg == '0);
    assign status.last_col  = last_col;
    assign status.out_free  = !out_valid_reg || m_ready;
    assign m_valid          = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg     <= START_RST;
            stop_reg      <= STOP_RST;
            steps_reg     <= STEPS_RST;
            ring_reg      <= '0;
            inc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_START: start_reg <= cfg_data;
                    CFG_STOP:  stop_reg  <= cfg_data;
                    CFG_STEPS: steps_reg <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_LOAD) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_ACCEPT: begin
                    if (s_last_point) ring_reg <= '0;
                    else if (int'(ring_reg) < MAX_RINGS) ring_reg <= ring_reg + 1'b1;
                end
                OP_DIV_END: inc_reg <= inc_sat;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                r_reg     <= s_radius;
                z_reg     <= s_height;
                n_reg     <= n_clamp;
                np_reg    <= np_calc;
                full_reg  <= full_calc;
                faces_reg <= (ring_reg != '0);
                base_reg  <= base_calc;
                prev_reg  <= base_calc - IDX_W'(np_calc);
                col_reg   <= '0;
                ang_reg   <= start_reg[15:0];
                neg_reg   <= diff[ANG_W];
                num_reg   <= DIV_W'(diff_mag) + DIV_W'(n_clamp >> 1);
                rem_reg   <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= rem_ge ? rem_sh - 7'(n_reg) : rem_sh;
                num_reg <= {num_reg[DIV_W-2:0], rem_ge};
            end
            OP_ANG_MUL: begin
                swap_reg <= swap_calc;
                quad_reg <= ang_reg[15:14];
                prod_reg <= 64'(fold_calc) * 64'(RAD_K);
            end
            OP_X:      x_reg  <= TRIG_W'((prod_reg + 64'd32768) >> 16);
            OP_X_SQ:   prod_reg <= 64'(x_reg) * 64'(x_reg);
            OP_X2:     x2_reg <= prod_reg[60:30];
            OP_HMUL:   prod_reg <= 64'(x2_reg) * 64'(t_reg);
            OP_RECIP: begin
                v_reg    <= v_sel;
                prod_reg <= 64'(v_sel) * 64'(horner_recip(cmd.k));
            end
            OP_CORR:   t_reg <= Q30_ONE - q_fix;
            OP_SMUL:   prod_reg <= 64'(x_reg) * 64'(t_reg);
            OP_SIN:    s_reg <= prod_reg[60:30];
            OP_UNFOLD: begin
                cs_reg <= cs_calc;
                sn_reg <= sn_calc;
            end
            OP_RMUL_X: prod_reg <= 64'($signed(64'(r_reg)) * $signed(64'(cs_reg)));
            OP_SCALE_X: px_reg <= pos_calc;
            OP_RMUL_Y: prod_reg <= 64'($signed(64'(r_reg)) * $signed(64'(sn_reg)));
            OP_SCALE_Y: py_reg <= pos_calc;
            OP_LOAD: begin
                m_pos_x        <= px_reg;
                m_pos_y        <= py_reg;
                m_pos_z        <= z_reg;
                m_vertex_index <= vi;
                m_run_end      <= last_col;
                if (faces_reg && (full_reg || col_reg < n_reg)) begin
                    m_faces_valid <= 1'b1;
                    if (full_reg) begin
                        m_face_a_first  <= ck;
                        m_face_a_second <= pk;
                        m_face_a_third  <= vi;
                        m_face_b_first  <= pk;
                        m_face_b_second <= pj;
                        m_face_b_third  <= vi;
                    end else begin
                        m_face_a_first  <= pj;
                        m_face_a_second <= pj1;
                        m_face_a_third  <= vi;
                        m_face_b_first  <= pj1;
                        m_face_b_second <= vi1;
                        m_face_b_third  <= vi;
                    end
                end else begin
                    m_faces_valid   <= 1'b0;
                    m_face_a_first  <= '0;
                    m_face_a_second <= '0;
                    m_face_a_third  <= '0;
                    m_face_b_first  <= '0;
                    m_face_b_second <= '0;
                    m_face_b_third  <= '0;
                end
                col_reg <= col_reg + 1'b1;
                ang_reg <= ang_reg + inc_reg[15:0];
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/surface_of_revolution_mesher.sv =====
// Sequential: one profile point word at a time, s_ready high only when idle.
// Each vertex runs the Horner sin/cos series, then two scale multiplies;
// the first point of a run also runs the bit-serial increment divider.
// Reset (aresetn low, synchronous) clears the ring counter and increment and
// restores start 0, stop one turn, 32 steps; the output register empties.
module surface_of_revolution_mesher import sorm_pkg::*; #(
    parameter int MAX_STEPS = DEF_MAX_STEPS,
    parameter int MAX_RINGS = DEF_MAX_RINGS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [ANG_W-1:0]         cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_radius,
    input  logic signed [DATA_W-1:0] s_height,
    input  logic                     s_last_point,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_pos_x,
    output logic signed [DATA_W-1:0] m_pos_y,
    output logic signed [DATA_W-1:0] m_pos_z,
    output logic [IDX_W-1:0]         m_vertex_index,
    output logic                     m_faces_valid,
    output logic [IDX_W-1:0]         m_face_a_first,
    output logic [IDX_W-1:0]         m_face_a_second,
    output logic [IDX_W-1:0]         m_face_a_third,
    output logic [IDX_W-1:0]         m_face_b_first,
    output logic [IDX_W-1:0]         m_face_b_second,
    output logic [IDX_W-1:0]         m_face_b_third,
    output logic                     m_run_end
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sorm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sorm_datapath #(
        .MAX_STEPS (MAX_STEPS),
        .MAX_RINGS (MAX_RINGS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_radius        (s_radius),
        .s_height        (s_height),
        .s_last_point    (s_last_point),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_pos_z         (m_pos_z),
        .m_vertex_index  (m_vertex_index),
        .m_faces_valid   (m_faces_valid),
        .m_face_a_first  (m_face_a_first),
        .m_face_a_second (m_face_a_second),
        .m_face_a_third  (m_face_a_third),
        .m_face_b_first  (m_face_b_first),
        .m_face_b_second (m_face_b_second),
        .m_face_b_third  (m_face_b_third),
        .m_run_end       (m_run_end),
        .cmd             (cmd),
        .status          (status)
    );

endmodule
